// File: hw/rtl/imu_dual_lowpass_offset_defines.svh
// Assertion macros shared by the IMU filter checker.
`ifndef IMU_DUAL_LOWPASS_OFFSET_DEFINES_SVH
`define IMU_DUAL_LOWPASS_OFFSET_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IDLO_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IDLO_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/idlo_pkg.sv
// Shared constants, types and helpers of the IMU dual low-pass filter.
package idlo_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int RAW_W       = 16;
	localparam int AXES        = 6;
	localparam int GYRO_AXES   = 3;
	localparam int DATA_W      = 32;
	localparam int GAIN_W      = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int WIDE_W      = 40;

	localparam logic [GAIN_W-1:0] GYRO_SCALE    = 16'd20477;
	localparam logic [GAIN_W-1:0] ACCEL_SCALE   = 16'd40121;
	localparam logic [GAIN_W-1:0] LP_GAIN_RESET = 16'd25281;
	localparam logic [GAIN_W-1:0] BL_GAIN_RESET = 16'd58982;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOWPASS_GAIN,
		REG_BLEND_GAIN,
		REG_GYRO_OFF_X,
		REG_GYRO_OFF_Y,
		REG_GYRO_OFF_Z,
		REG_ACCEL_OFF_X,
		REG_ACCEL_OFF_Y,
		REG_ACCEL_OFF_Z
	} cfg_reg_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_SCALE,
		SQ_LP_MUL,
		SQ_LP_UPD,
		SQ_BL_MUL,
		SQ_BL_UPD
	} seq_state_t;

	// Phase strobes broadcast from the sequencer to every lane.
	typedef struct packed {
		logic load;
		logic scale;
		logic lp_mul;
		logic lp_upd;
		logic bl_mul;
		logic bl_upd;
		logic seed;
	} step_t;

	typedef logic [AXES-1:0][DATA_W-1:0] axis_vec_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic fits;
		fits = (&v[WIDE_W-1:DATA_W-1]) || !(|v[WIDE_W-1:DATA_W-1]);
		if (fits)
			return v[DATA_W-1:0];
		else if (v[WIDE_W-1])
			return {1'b1, {(DATA_W-1){1'b0}}};
		else
			return {1'b0, {(DATA_W-1){1'b1}}};
	endfunction

endpackage

// File: hw/rtl/idlo_lane.sv
// One axis: scale to Q16.16, first-order low-pass, blend with offset.
module idlo_lane (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  idlo_pkg::step_t                      step,
	input  logic signed [idlo_pkg::RAW_W-1:0]    raw,
	input  logic [idlo_pkg::GAIN_W-1:0]          scale_k,
	input  logic [idlo_pkg::GAIN_W-1:0]          lowpass_gain,
	input  logic [idlo_pkg::GAIN_W-1:0]          blend_gain,
	input  logic signed [idlo_pkg::DATA_W-1:0]   offset,
	output logic signed [idlo_pkg::DATA_W-1:0]   blend_next
);
	import idlo_pkg::*;

	localparam int SC_PW  = SAMPLE_BITS + GAIN_W + 1;
	localparam int SC_W   = SC_PW + 1;
	localparam int DIFF_W = DATA_W + 1;
	localparam int PROD_W = GAIN_W + 1 + DIFF_W;
	localparam int RND_W  = PROD_W + 1;
	localparam int RES_W  = RND_W - GAIN_W;

	localparam logic signed [SC_W-1:0]  SC_HALF  = {{(SC_W-8){1'b0}}, 8'h80};
	localparam logic signed [RND_W-1:0] Q16_HALF = {{(RND_W-GAIN_W){1'b0}}, 1'b1,
		{(GAIN_W-1){1'b0}}};

	logic signed [SAMPLE_BITS-1:0] raw_s1;
	logic signed [DATA_W-1:0]      x_s2;
	logic signed [PROD_W-1:0]      lp_prod_s3;
	logic signed [PROD_W-1:0]      bl_prod_s4;
	logic signed [DATA_W-1:0]      lp_q;
	logic signed [DATA_W-1:0]      bl_q;

	logic signed [SC_PW-1:0]  sc_prod;
	logic signed [SC_W-1:0]   sc_rnd;
	logic signed [WIDE_W-1:0] sc_wide;
	logic signed [DIFF_W-1:0] lp_diff;
	logic signed [DIFF_W-1:0] bl_diff;
	logic signed [PROD_W-1:0] lp_mul;
	logic signed [PROD_W-1:0] bl_mul;
	logic signed [RND_W-1:0]  lp_rnd;
	logic signed [RND_W-1:0]  bl_rnd;
	logic signed [WIDE_W-1:0] lp_wide;
	logic signed [WIDE_W-1:0] bl_wide;
	logic signed [DATA_W-1:0] lp_next;

	// Scale: round(raw * k / 2^8), halves toward +infinity.
	always_comb begin
		sc_prod = raw_s1 * $signed({1'b0, scale_k});
		sc_rnd  = {sc_prod[SC_PW-1], sc_prod} + SC_HALF;
		sc_wide = {{(WIDE_W-(SC_W-8)){sc_rnd[SC_W-1]}}, sc_rnd[SC_W-1:8]};
	end

	// Low-pass: lp += round(gain * (x - lp) / 2^16); a seed sets lp = x.
	always_comb begin
		lp_diff = {x_s2[DATA_W-1], x_s2} - {lp_q[DATA_W-1], lp_q};
		lp_mul  = $signed({1'b0, lowpass_gain}) * lp_diff;
		lp_rnd  = {lp_prod_s3[PROD_W-1], lp_prod_s3} + Q16_HALF;
		lp_wide = {{(WIDE_W-RES_W){lp_rnd[RND_W-1]}}, lp_rnd[RND_W-1:GAIN_W]}
			+ {{(WIDE_W-DATA_W){lp_q[DATA_W-1]}}, lp_q};
		lp_next = step.seed ? x_s2 : sat32(lp_wide);
	end

	// Blend: (1-b)*bl + b*lp = bl + b*(lp - bl), one product; less the offset.
	always_comb begin
		bl_diff = {lp_q[DATA_W-1], lp_q} - {bl_q[DATA_W-1], bl_q};
		bl_mul  = $signed({1'b0, blend_gain}) * bl_diff;
		bl_rnd  = {bl_prod_s4[PROD_W-1], bl_prod_s4} + Q16_HALF;
		bl_wide = {{(WIDE_W-RES_W){bl_rnd[RND_W-1]}}, bl_rnd[RND_W-1:GAIN_W]}
			+ {{(WIDE_W-DATA_W){bl_q[DATA_W-1]}}, bl_q}
			- {{(WIDE_W-DATA_W){offset[DATA_W-1]}}, offset};
		blend_next = step.seed ? x_s2 : sat32(bl_wide);
	end

	always_ff @(posedge clk) begin
		if (step.load)
			raw_s1 <= raw[SAMPLE_BITS-1:0];
		if (step.scale)
			x_s2 <= sat32(sc_wide);
		if (step.lp_mul)
			lp_prod_s3 <= lp_mul;
		if (step.bl_mul)
			bl_prod_s4 <= bl_mul;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q <= '0;
			bl_q <= '0;
		end else begin
			if (step.lp_upd)
				lp_q <= lp_next;
			if (step.bl_upd)
				bl_q <= blend_next;
		end
	end

endmodule

// File: hw/rtl/idlo_seq.sv
// Phase sequencer that walks all lanes through one sample at a time.
module idlo_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            command,
	input  logic            out_room,
	output logic            in_stall,
	output idlo_pkg::step_t step
);
	import idlo_pkg::*;

	seq_state_t state_q;
	seq_state_t state_d;
	logic       cmd_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_IDLE:   if (in_valid) begin
				state_d = SQ_SCALE;
			end
			SQ_SCALE:  state_d = SQ_LP_MUL;
			SQ_LP_MUL: state_d = SQ_LP_UPD;
			SQ_LP_UPD: state_d = SQ_BL_MUL;
			SQ_BL_MUL: state_d = SQ_BL_UPD;
			// hold until the output register can take the result
			SQ_BL_UPD: if (out_room) begin
				state_d = SQ_IDLE;
			end
			default:   state_d = SQ_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		step     = '0;
		step.seed = cmd_q;
		unique case (state_q)
			SQ_IDLE: begin
				in_stall  = 1'b0;
				step.load = in_valid;
			end
			SQ_SCALE:  step.scale  = 1'b1;
			SQ_LP_MUL: step.lp_mul = 1'b1;
			SQ_LP_UPD: step.lp_upd = 1'b1;
			SQ_BL_MUL: step.bl_mul = 1'b1;
			SQ_BL_UPD: step.bl_upd = out_room;
			default:   in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			cmd_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (step.load)
				cmd_q <= command;
		end
	end

endmodule

// File: hw/rtl/idlo_merge.sv
// Output register that gathers the six lane results into one transfer.
module idlo_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  idlo_pkg::step_t      step,
	input  idlo_pkg::axis_vec_t  lane_value,
	input  logic                 out_stall,
	output logic                 out_valid,
	output idlo_pkg::axis_vec_t  out_data,
	output logic                 out_room
);
	import idlo_pkg::*;

	logic      valid_q;
	axis_vec_t data_q;

	assign out_room  = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (step.bl_upd)
			valid_q <= 1'b1;
		else if (!out_stall)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step.bl_upd)
			data_q <= lane_value;
	end

endmodule

// File: hw/rtl/imu_dual_lowpass_offset.sv
// Top level of the six-axis IMU scale, low-pass and offset blend filter.
//
// Input channel (in_valid/in_stall) carries one raw six-axis sample and a
// command bit: 0 runs both filter stages, 1 seeds both stages with the
// scaled sample. Output channel (out_valid/out_stall) returns one filtered
// six-axis result per sample, in signed Q16.16.
// Six lanes, one per axis, work in parallel; a sequencer steps them through
// scale, low-pass multiply, low-pass update, blend multiply and blend update.
// The lanes hold one sample at a time; the next sample is taken once
// the previous result has landed in the output register.
// A finished result waits in the output register while out_stall is high;
// a new sample is accepted meanwhile and runs until its final update, where
// it holds until the register frees up.
// Reset clears both filter states to zero, sets the gains to their defaults
// and the offsets to zero. Configuration writes apply at once and must be
// issued while no sample is in flight.
module imu_dual_lowpass_offset (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_write,
	input  logic [idlo_pkg::CFG_IDX_W-1:0]            cfg_index,
	input  logic [idlo_pkg::DATA_W-1:0]               cfg_data,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic                                      command,
	input  logic signed [idlo_pkg::RAW_W-1:0]         raw_gyro_x,
	input  logic signed [idlo_pkg::RAW_W-1:0]         raw_gyro_y,
	input  logic signed [idlo_pkg::RAW_W-1:0]         raw_gyro_z,
	input  logic signed [idlo_pkg::RAW_W-1:0]         raw_accel_x,
	input  logic signed [idlo_pkg::RAW_W-1:0]         raw_accel_y,
	input  logic signed [idlo_pkg::RAW_W-1:0]         raw_accel_z,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic signed [idlo_pkg::DATA_W-1:0]        rate_x,
	output logic signed [idlo_pkg::DATA_W-1:0]        rate_y,
	output logic signed [idlo_pkg::DATA_W-1:0]        rate_z,
	output logic signed [idlo_pkg::DATA_W-1:0]        accel_x,
	output logic signed [idlo_pkg::DATA_W-1:0]        accel_y,
	output logic signed [idlo_pkg::DATA_W-1:0]        accel_z
);
	import idlo_pkg::*;

	logic [GAIN_W-1:0]              lp_gain_q;
	logic [GAIN_W-1:0]              bl_gain_q;
	logic [AXES-1:0][DATA_W-1:0]    offset_q;
	logic [AXES-1:0][RAW_W-1:0]     raw_vec;
	axis_vec_t                      lane_value;
	axis_vec_t                      out_data;
	step_t                          step;
	logic                           out_room;

	assign raw_vec = {raw_accel_z, raw_accel_y, raw_accel_x,
		raw_gyro_z, raw_gyro_y, raw_gyro_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_gain_q <= LP_GAIN_RESET;
			bl_gain_q <= BL_GAIN_RESET;
			offset_q  <= '0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOWPASS_GAIN: lp_gain_q   <= cfg_data[GAIN_W-1:0];
				REG_BLEND_GAIN:   bl_gain_q   <= cfg_data[GAIN_W-1:0];
				REG_GYRO_OFF_X:   offset_q[0] <= cfg_data;
				REG_GYRO_OFF_Y:   offset_q[1] <= cfg_data;
				REG_GYRO_OFF_Z:   offset_q[2] <= cfg_data;
				REG_ACCEL_OFF_X:  offset_q[3] <= cfg_data;
				REG_ACCEL_OFF_Y:  offset_q[4] <= cfg_data;
				REG_ACCEL_OFF_Z:  offset_q[5] <= cfg_data;
				default:          lp_gain_q   <= lp_gain_q;
			endcase
		end
	end

	idlo_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.out_room (out_room),
		.in_stall (in_stall),
		.step     (step)
	);

	for (genvar i = 0; i < AXES; i++) begin : g_lane
		idlo_lane u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.step         (step),
			.raw          ($signed(raw_vec[i])),
			.scale_k      ((i < GYRO_AXES) ? GYRO_SCALE : ACCEL_SCALE),
			.lowpass_gain (lp_gain_q),
			.blend_gain   (bl_gain_q),
			.offset       ($signed(offset_q[i])),
			.blend_next   (lane_value[i])
		);
	end

	idlo_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.lane_value (lane_value),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_data   (out_data),
		.out_room   (out_room)
	);

	assign rate_x  = $signed(out_data[0]);
	assign rate_y  = $signed(out_data[1]);
	assign rate_z  = $signed(out_data[2]);
	assign accel_x = $signed(out_data[3]);
	assign accel_y = $signed(out_data[4]);
	assign accel_z = $signed(out_data[5]);

endmodule

// File: hw/rtl/idlo_checker.sv
// Port-level checks of the IMU filter, bound to the top level.
`include "imu_dual_lowpass_offset_defines.svh"

module idlo_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [idlo_pkg::DATA_W-1:0] rate_x,
	input logic signed [idlo_pkg::DATA_W-1:0] rate_y,
	input logic signed [idlo_pkg::DATA_W-1:0] rate_z,
	input logic signed [idlo_pkg::DATA_W-1:0] accel_x,
	input logic signed [idlo_pkg::DATA_W-1:0] accel_y,
	input logic signed [idlo_pkg::DATA_W-1:0] accel_z
);
	import idlo_pkg::*;

	// the input stays stalled while a sample occupies the lanes after its transfer
	`IDLO_ASSERT_NXT(a_busy_after_in, clk, arst_n, in_valid && !in_stall,
		in_stall ##1 in_stall ##1 in_stall ##1 in_stall ##1 in_stall,
		"input taken while lanes busy")

	// with the output register empty, the result follows without a hold
	`IDLO_ASSERT_NXT(a_latency, clk, arst_n, in_valid && !in_stall && !out_valid,
		1'b1 ##5 out_valid, "result missing six cycles after input")

	// a result only appears at the end of a busy phase
	`IDLO_ASSERT_IMP(a_out_from_busy, clk, arst_n, $rose(out_valid), $past(in_stall),
		"result appeared without a sample in flight")

	`IDLO_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(rate_x) && $stable(rate_y) && $stable(rate_z)
		&& $stable(accel_x) && $stable(accel_y) && $stable(accel_z),
		"stalled result changed")

endmodule

bind imu_dual_lowpass_offset idlo_checker u_idlo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.rate_x    (rate_x),
	.rate_y    (rate_y),
	.rate_z    (rate_z),
	.accel_x   (accel_x),
	.accel_y   (accel_y),
	.accel_z   (accel_z)
);
